// ===== design/dlsel_pkg.sv =====
package dlsel_pkg;

  // Field widths
  localparam int unsigned PT_W       = 16;
  localparam int unsigned ETA_W      = 14;
  localparam int unsigned ETA_MAX_W  = 13;
  localparam int unsigned ID_W       = 32;
  localparam int unsigned CNT_W      = 2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Species codes, both signs
  localparam logic [ID_W-1:0] ELE_ID     = ID_W'(11);
  localparam logic [ID_W-1:0] MU_ID      = ID_W'(13);
  localparam logic [ID_W-1:0] ELE_ID_NEG = ~ELE_ID + ID_W'(1);
  localparam logic [ID_W-1:0] MU_ID_NEG  = ~MU_ID + ID_W'(1);

  // Counters saturate here
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(2);

  // Queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Reset values of the registers
  localparam logic [PT_W-1:0]      RST_ELE_LEAD_PT_MIN      = PT_W'(272);
  localparam logic [PT_W-1:0]      RST_ELE_SUB_PT_MIN       = PT_W'(192);
  localparam logic [PT_W-1:0]      RST_ELE_LEAD_PT_PROPOSED = PT_W'(368);
  localparam logic [PT_W-1:0]      RST_MU_LEAD_PT_MIN       = PT_W'(272);
  localparam logic [PT_W-1:0]      RST_MU_SUB_PT_MIN        = PT_W'(128);
  localparam logic [ETA_MAX_W-1:0] RST_ELE_ETA_MAX          = ETA_MAX_W'(2560);
  localparam logic [ETA_MAX_W-1:0] RST_MU_ETA_MAX           = ETA_MAX_W'(2458);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ELE_LEAD_PT_MIN      = 3'd0,
    REG_ELE_SUB_PT_MIN       = 3'd1,
    REG_ELE_LEAD_PT_PROPOSED = 3'd2,
    REG_MU_LEAD_PT_MIN       = 3'd3,
    REG_MU_SUB_PT_MIN        = 3'd4,
    REG_ELE_ETA_MAX          = 3'd5,
    REG_MU_ETA_MAX           = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [PT_W-1:0]      ele_lead_pt_min;
    logic [PT_W-1:0]      ele_sub_pt_min;
    logic [PT_W-1:0]      ele_lead_pt_proposed;
    logic [PT_W-1:0]      mu_lead_pt_min;
    logic [PT_W-1:0]      mu_sub_pt_min;
    logic [ETA_MAX_W-1:0] ele_eta_max;
    logic [ETA_MAX_W-1:0] mu_eta_max;
  } cfg_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic            is_ele;
    logic            is_mu;
    logic            in_eta;
    logic [PT_W-1:0] pt;
    logic            last;
  } item_t;

  typedef struct packed {
    logic                  empty;
    logic                  full;
    logic [FIFO_CNT_W-1:0] count;
  } fifo_stat_t;

  typedef struct packed {
    logic [CNT_W-1:0] seen;
    logic [CNT_W-1:0] kept;
    logic [PT_W-1:0]  top;
    logic [PT_W-1:0]  second;
  } flavor_t;

  typedef struct packed {
    logic ele_count_pass;
    logic ele_eta_pass;
    logic ele_pt_pass;
    logic ele_pt_new_fail;
    logic mu_count_pass;
    logic mu_eta_pass;
    logic mu_pt_pass;
    logic event_cut;
    logic event_cut_new;
  } result_t;

endpackage

// ===== design/dlsel_in_if.sv =====
interface dlsel_in_if;
  logic                                valid;
  logic                                ready;
  logic                                has_particle;
  logic signed [dlsel_pkg::ID_W-1:0]   species_id;
  logic signed [dlsel_pkg::ETA_W-1:0]  eta;
  logic        [dlsel_pkg::PT_W-1:0]   pt;
  logic                                end_of_event;

  modport source (
    output valid, has_particle, species_id, eta, pt, end_of_event,
    input  ready
  );
  modport sink (
    input  valid, has_particle, species_id, eta, pt, end_of_event,
    output ready
  );
endinterface

// ===== design/dlsel_out_if.sv =====
interface dlsel_out_if;
  logic valid;
  logic ready;
  logic ele_count_pass;
  logic ele_eta_pass;
  logic ele_pt_pass;
  logic ele_pt_new_fail;
  logic mu_count_pass;
  logic mu_eta_pass;
  logic mu_pt_pass;
  logic event_cut;
  logic event_cut_new;

  modport source (
    output valid, ele_count_pass, ele_eta_pass, ele_pt_pass, ele_pt_new_fail,
           mu_count_pass, mu_eta_pass, mu_pt_pass, event_cut, event_cut_new,
    input  ready
  );
  modport sink (
    input  valid, ele_count_pass, ele_eta_pass, ele_pt_pass, ele_pt_new_fail,
           mu_count_pass, mu_eta_pass, mu_pt_pass, event_cut, event_cut_new,
    output ready
  );
endinterface

// ===== design/dlsel_fifo.sv =====
module dlsel_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  dlsel_pkg::item_t     item_i,
  input  logic                 pop_i,
  output dlsel_pkg::item_t     item_o,
  output dlsel_pkg::fifo_stat_t stat_o
);

  dlsel_pkg::item_t                     mem_q [dlsel_pkg::FIFO_DEPTH];
  logic [dlsel_pkg::FIFO_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [dlsel_pkg::FIFO_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [dlsel_pkg::FIFO_CNT_W-1:0]     count_q, count_d;

  // Pointer wrap at the queue depth
  function automatic logic [dlsel_pkg::FIFO_PTR_W-1:0] ptr_inc(
    logic [dlsel_pkg::FIFO_PTR_W-1:0] p
  );
    logic [dlsel_pkg::FIFO_PTR_W-1:0] r;
    if (p == dlsel_pkg::FIFO_PTR_W'(dlsel_pkg::FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + dlsel_pkg::FIFO_PTR_W'(1);
    end
    return r;
  endfunction

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + dlsel_pkg::FIFO_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - dlsel_pkg::FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == dlsel_pkg::FIFO_CNT_W'(dlsel_pkg::FIFO_DEPTH));
  assign stat_o.count = count_q;

endmodule

// ===== design/dlsel_front.sv =====
module dlsel_front (
  dlsel_in_if.sink              in_i,
  input  dlsel_pkg::cfg_t       cfg_i,
  input  dlsel_pkg::fifo_stat_t fifo_stat_i,
  output logic                  push_o,
  output dlsel_pkg::item_t      item_o
);

  logic [dlsel_pkg::ETA_W-1:0] eta_raw;
  logic [dlsel_pkg::ETA_W-1:0] abs_eta;
  logic [dlsel_pkg::ID_W-1:0]  id_raw;
  logic                        ele_code;
  logic                        mu_code;
  logic [dlsel_pkg::ETA_W-1:0] eta_lim;

  // Accept whenever the queue has a free slot
  assign in_i.ready = !fifo_stat_i.full;
  assign push_o     = in_i.valid && !fifo_stat_i.full;

  // Species decode, either sign
  assign id_raw   = in_i.species_id;
  assign ele_code = (id_raw == dlsel_pkg::ELE_ID) || (id_raw == dlsel_pkg::ELE_ID_NEG);
  assign mu_code  = (id_raw == dlsel_pkg::MU_ID)  || (id_raw == dlsel_pkg::MU_ID_NEG);

  // Magnitude of eta; the most negative code maps to 2^(ETA_W-1)
  assign eta_raw = in_i.eta;
  assign abs_eta = eta_raw[dlsel_pkg::ETA_W-1] ? (~eta_raw + dlsel_pkg::ETA_W'(1)) : eta_raw;

  // Limit of the flavor at hand
  assign eta_lim = mu_code ? dlsel_pkg::ETA_W'(cfg_i.mu_eta_max)
                           : dlsel_pkg::ETA_W'(cfg_i.ele_eta_max);

  always_comb begin
    item_o.is_ele = in_i.has_particle && ele_code;
    item_o.is_mu  = in_i.has_particle && mu_code;
    item_o.in_eta = (abs_eta <= eta_lim);
    item_o.pt     = in_i.pt;
    item_o.last   = in_i.end_of_event;
  end

endmodule

// ===== design/dlsel_back.sv =====
module dlsel_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dlsel_pkg::cfg_t       cfg_i,
  input  dlsel_pkg::fifo_stat_t fifo_stat_i,
  input  dlsel_pkg::item_t      item_i,
  output logic                  pop_o,
  dlsel_out_if.source           out_o
);

  dlsel_pkg::flavor_t ele_q, ele_d, ele_upd;
  dlsel_pkg::flavor_t mu_q, mu_d, mu_upd;
  dlsel_pkg::result_t res_q, res_d;
  logic               out_valid_q, out_valid_d;
  logic               slot_free;
  logic               e_cnt, e_eta, e_old, e_new, e_fail;
  logic               m_cnt, m_eta, m_pt;

  // Count and top-two update for one particle of a flavor
  function automatic dlsel_pkg::flavor_t take_particle(
    dlsel_pkg::flavor_t        f,
    logic                      in_eta,
    logic [dlsel_pkg::PT_W-1:0] pt
  );
    dlsel_pkg::flavor_t r;
    r = f;
    if (f.seen != dlsel_pkg::CNT_SAT) begin
      r.seen = f.seen + dlsel_pkg::CNT_W'(1);
    end
    if (in_eta) begin
      if (f.kept == '0) begin
        r.top = pt;
      end else if (pt > f.top) begin
        r.second = f.top;
        r.top    = pt;
      end else if ((f.kept == dlsel_pkg::CNT_W'(1)) || (pt > f.second)) begin
        r.second = pt;
      end
      if (f.kept != dlsel_pkg::CNT_SAT) begin
        r.kept = f.kept + dlsel_pkg::CNT_W'(1);
      end
    end
    return r;
  endfunction

  // Per-flavor state after the head word
  assign ele_upd = item_i.is_ele ? take_particle(ele_q, item_i.in_eta, item_i.pt) : ele_q;
  assign mu_upd  = item_i.is_mu  ? take_particle(mu_q,  item_i.in_eta, item_i.pt) : mu_q;

  // A closing word waits until the result register can take it
  assign slot_free = !out_valid_q || out_o.ready;
  assign pop_o     = !fifo_stat_i.empty && (!item_i.last || slot_free);

  // Stage flags on the closing word
  always_comb begin
    e_cnt  = (ele_upd.seen == dlsel_pkg::CNT_SAT);
    e_eta  = e_cnt && (ele_upd.kept == dlsel_pkg::CNT_SAT);
    e_old  = e_eta && (ele_upd.top > cfg_i.ele_lead_pt_min)
                   && (ele_upd.second > cfg_i.ele_sub_pt_min);
    e_new  = e_old && (ele_upd.top > cfg_i.ele_lead_pt_proposed);
    e_fail = e_old && !e_new;
    m_cnt  = (mu_upd.seen == dlsel_pkg::CNT_SAT);
    m_eta  = m_cnt && (mu_upd.kept == dlsel_pkg::CNT_SAT);
    m_pt   = m_eta && (mu_upd.top > cfg_i.mu_lead_pt_min)
                   && (mu_upd.second > cfg_i.mu_sub_pt_min);

    res_d.ele_count_pass  = e_cnt;
    res_d.ele_eta_pass    = e_eta;
    res_d.ele_pt_pass     = e_new;
    res_d.ele_pt_new_fail = e_fail;
    res_d.mu_count_pass   = m_cnt;
    res_d.mu_eta_pass     = m_eta;
    res_d.mu_pt_pass      = m_pt;
    res_d.event_cut       = !e_new && !m_pt;
    res_d.event_cut_new   = e_fail && !m_pt;
  end

  // Next state: clear after a closing word
  always_comb begin
    ele_d = ele_q;
    mu_d  = mu_q;
    if (pop_o) begin
      if (item_i.last) begin
        ele_d = '0;
        mu_d  = '0;
      end else begin
        ele_d = ele_upd;
        mu_d  = mu_upd;
      end
    end
    out_valid_d = (out_valid_q && !out_o.ready) || (pop_o && item_i.last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ele_q       <= '0;
      mu_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ele_q       <= ele_d;
      mu_q        <= mu_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.last) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.ele_count_pass  = res_q.ele_count_pass;
  assign out_o.ele_eta_pass    = res_q.ele_eta_pass;
  assign out_o.ele_pt_pass     = res_q.ele_pt_pass;
  assign out_o.ele_pt_new_fail = res_q.ele_pt_new_fail;
  assign out_o.mu_count_pass   = res_q.mu_count_pass;
  assign out_o.mu_eta_pass     = res_q.mu_eta_pass;
  assign out_o.mu_pt_pass      = res_q.mu_pt_pass;
  assign out_o.event_cut       = res_q.event_cut;
  assign out_o.event_cut_new   = res_q.event_cut_new;

endmodule

// ===== design/dilepton_event_selector_top.sv =====
// Dilepton event selector.
// in_i carries one particle word per handshake (has_particle, species_id, eta,
// pt, end_of_event); a word is taken when valid and ready are both high.
// Electrons (|id| 11) and muons (|id| 13) are counted, checked against their
// eta limit and their two highest pT values tracked; other words only matter
// for end_of_event. The word with end_of_event produces one result word on
// out_o with the stage flags, and the per-event state is cleared.
// Throughput: one word per cycle while out_o takes its results. The front
// classifies and writes a two-entry queue; the back updates the flavor state
// from the queue head on each pop. A closing word passes through the queue
// and then the result register before its result shows on out_o.
// When out_o stalls, words ahead of a closing word still drain; the closing
// word waits at the queue head until the result register is free, and
// in_i.ready drops once the queue has filled up behind it.
// cfg_we_i/cfg_idx_i/cfg_data_i write the threshold registers; write only
// while no event is in flight. Indexes beyond the list are ignored.
// Reset clears the queue, the flavor state and the result valid, and loads
// the default thresholds.
module dilepton_event_selector_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  dlsel_in_if.sink                              in_i,
  dlsel_out_if.source                           out_o,
  input  logic                                  cfg_we_i,
  input  logic [dlsel_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dlsel_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  dlsel_pkg::cfg_t       cfg_q, cfg_d;
  dlsel_pkg::fifo_stat_t fifo_stat;
  dlsel_pkg::item_t      push_item;
  dlsel_pkg::item_t      head_item;
  logic                  push;
  logic                  pop;

  // Threshold registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (dlsel_pkg::cfg_reg_e'(cfg_idx_i))
        dlsel_pkg::REG_ELE_LEAD_PT_MIN:
          cfg_d.ele_lead_pt_min = dlsel_pkg::PT_W'(cfg_data_i);
        dlsel_pkg::REG_ELE_SUB_PT_MIN:
          cfg_d.ele_sub_pt_min = dlsel_pkg::PT_W'(cfg_data_i);
        dlsel_pkg::REG_ELE_LEAD_PT_PROPOSED:
          cfg_d.ele_lead_pt_proposed = dlsel_pkg::PT_W'(cfg_data_i);
        dlsel_pkg::REG_MU_LEAD_PT_MIN:
          cfg_d.mu_lead_pt_min = dlsel_pkg::PT_W'(cfg_data_i);
        dlsel_pkg::REG_MU_SUB_PT_MIN:
          cfg_d.mu_sub_pt_min = dlsel_pkg::PT_W'(cfg_data_i);
        dlsel_pkg::REG_ELE_ETA_MAX:
          cfg_d.ele_eta_max = cfg_data_i[dlsel_pkg::ETA_MAX_W-1:0];
        dlsel_pkg::REG_MU_ETA_MAX:
          cfg_d.mu_eta_max = cfg_data_i[dlsel_pkg::ETA_MAX_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ele_lead_pt_min      <= dlsel_pkg::RST_ELE_LEAD_PT_MIN;
      cfg_q.ele_sub_pt_min       <= dlsel_pkg::RST_ELE_SUB_PT_MIN;
      cfg_q.ele_lead_pt_proposed <= dlsel_pkg::RST_ELE_LEAD_PT_PROPOSED;
      cfg_q.mu_lead_pt_min       <= dlsel_pkg::RST_MU_LEAD_PT_MIN;
      cfg_q.mu_sub_pt_min        <= dlsel_pkg::RST_MU_SUB_PT_MIN;
      cfg_q.ele_eta_max          <= dlsel_pkg::RST_ELE_ETA_MAX;
      cfg_q.mu_eta_max           <= dlsel_pkg::RST_MU_ETA_MAX;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front: accept and classify
  dlsel_front u_front (
    .in_i        (in_i),
    .cfg_i       (cfg_q),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .item_o      (push_item)
  );

  // Queue between front and back
  dlsel_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (push_item),
    .pop_i  (pop),
    .item_o (head_item),
    .stat_o (fifo_stat)
  );

  // Back: flavor state and result register
  dlsel_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .fifo_stat_i (fifo_stat),
    .item_i      (head_item),
    .pop_o       (pop),
    .out_o       (out_o)
  );

  // Queue never overfills
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_stat.count <= dlsel_pkg::FIFO_CNT_W'(dlsel_pkg::FIFO_DEPTH))
    else $error("queue count above depth");

  // Back never reads an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_stat.empty)
    else $error("pop from empty queue");

  // A word pushed into an empty queue is at the head next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && fifo_stat.empty) |=> !fifo_stat.empty)
    else $error("pushed word lost");

  // Proposed-limit failure excludes the tight pass and needs the eta stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ele_pt_new_fail) |-> (out_o.ele_eta_pass && !out_o.ele_pt_pass))
    else $error("inconsistent electron flags");

endmodule
